// ===== hdl/clht_pkg.sv =====
package clht_pkg;

  localparam int unsigned SLOT_COUNT = 64;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_SET      = 3'd1,
    CMD_TOUCH    = 3'd2,
    CMD_REPORT   = 3'd3,
    CMD_REFRESH  = 3'd4,
    CMD_EXPIRE   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CONNECTING = 3'd0,
    ST_ONLINE     = 3'd1,
    ST_DEGRADED   = 3'd2,
    ST_LOCKED     = 3'd3,
    ST_OFFLINE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_MIN_SAMPLE = 3'd0,
    CFG_DEGRADE    = 3'd1,
    CFG_RECOVER    = 3'd2,
    CFG_BAD_NEED   = 3'd3,
    CFG_GOOD_NEED  = 3'd4,
    CFG_TIMEOUT    = 3'd5
  } cfg_idx_e;

  localparam logic [31:0] MIN_SAMPLE_RST = 32'd200;
  localparam logic [9:0]  DEGRADE_RST    = 10'd50;
  localparam logic [9:0]  RECOVER_RST    = 10'd20;
  localparam logic [2:0]  BAD_NEED_RST   = 3'd3;
  localparam logic [2:0]  GOOD_NEED_RST  = 3'd5;
  localparam logic [31:0] TIMEOUT_RST    = 32'd5000;

  localparam logic [6:0]  COUNT_MAX      = 7'd127;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] seen_ms;
    logic [2:0]  bad;
    logic [2:0]  good;
  } rec_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan_rd;
    logic scan_chk;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic scan_last;
  } dp_sts_t;

  function automatic logic [2:0] bump(input logic [2:0] c, input logic [2:0] limit);
    logic [3:0] n;
    n = {1'b0, c} + 4'd1;
    return (n < {1'b0, limit}) ? n[2:0] : limit;
  endfunction

endpackage

// ===== hdl/clht_in_if.sv =====
interface clht_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [5:0]  slot;
  logic [2:0]  status_value;
  logic [9:0]  loss_pm;
  logic [31:0] sample_size;
  logic [31:0] now_ms;

  modport source (
    output valid, cmd, slot, status_value, loss_pm, sample_size, now_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, status_value, loss_pm, sample_size, now_ms,
    output ready
  );
endinterface

// ===== hdl/clht_out_if.sv =====
interface clht_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [2:0] status_out;
  logic [6:0] expired_count;

  modport source (
    output valid, found, status_out, expired_count,
    input  ready
  );
  modport sink (
    input  valid, found, status_out, expired_count,
    output ready
  );
endinterface

// ===== hdl/clht_ctrl.sv =====
module clht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  clht_pkg::dp_sts_t sts_i,
  output clht_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_EXEC     = 5'b00010,
    S_SCAN_RD  = 5'b00100,
    S_SCAN_CHK = 5'b01000,
    S_PUSH     = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_scan) begin
          state_d = S_SCAN_RD;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_PUSH;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d        = sts_i.scan_last ? S_PUSH : S_SCAN_RD;
      end
      S_PUSH: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ===== hdl/clht_datapath.sv =====
module clht_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clht_pkg::dp_cmd_t cmd_i,
  output clht_pkg::dp_sts_t sts_o,
  input  logic [2:0]        in_cmd_i,
  input  logic [5:0]        in_slot_i,
  input  logic [2:0]        in_status_value_i,
  input  logic [9:0]        in_loss_pm_i,
  input  logic [31:0]       in_sample_size_i,
  input  logic [31:0]       in_now_ms_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic              out_found_o,
  output logic [2:0]        out_status_out_o,
  output logic [6:0]        out_expired_count_o
);

  localparam int unsigned SW = clht_pkg::SLOT_W;

  logic [31:0] min_sample_q;
  logic [9:0]  degrade_q;
  logic [9:0]  recover_q;
  logic [2:0]  bad_need_q;
  logic [2:0]  good_need_q;
  logic [31:0] timeout_q;

  logic [2:0]  cmd_q;
  logic [5:0]  slot_q;
  logic [2:0]  stv_q;
  logic [9:0]  loss_q;
  logic [31:0] samples_q;
  logic [31:0] now_q;

  clht_pkg::rec_t mem [clht_pkg::SLOT_COUNT];
  clht_pkg::rec_t rd_data_q;
  logic [clht_pkg::SLOT_COUNT-1:0] valid_q;
  logic        valid_rd_q;
  logic [SW-1:0] idx_q;
  logic [6:0]  cnt_q;

  logic        res_found_q;
  logic [2:0]  res_status_q;
  logic [6:0]  res_count_q;
  logic        out_found_q;
  logic [2:0]  out_status_q;
  logic [6:0]  out_count_q;

  logic          rd_en;
  logic [SW-1:0] raddr;
  logic          mem_we;
  logic [SW-1:0] waddr;
  clht_pkg::rec_t mem_wdata;

  logic          in_range;
  logic          was_valid;
  logic [2:0]    stv_clamp;
  logic [2:0]    bad_n;
  logic [2:0]    good_n;
  logic [2:0]    rep_status;
  clht_pkg::rec_t rec_new;
  logic          ex_we;
  logic          ex_valid_set;
  logic          upd;
  logic          ex_found;
  logic [2:0]    ex_status;
  logic          hit;
  logic [6:0]    cnt_inc;
  logic          scan_last;
  clht_pkg::rec_t rec_exp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sample_q <= clht_pkg::MIN_SAMPLE_RST;
      degrade_q    <= clht_pkg::DEGRADE_RST;
      recover_q    <= clht_pkg::RECOVER_RST;
      bad_need_q   <= clht_pkg::BAD_NEED_RST;
      good_need_q  <= clht_pkg::GOOD_NEED_RST;
      timeout_q    <= clht_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clht_pkg::CFG_MIN_SAMPLE: min_sample_q <= cfg_wdata_i;
        clht_pkg::CFG_DEGRADE:    degrade_q    <= cfg_wdata_i[9:0];
        clht_pkg::CFG_RECOVER:    recover_q    <= cfg_wdata_i[9:0];
        clht_pkg::CFG_BAD_NEED:   bad_need_q   <= cfg_wdata_i[2:0];
        clht_pkg::CFG_GOOD_NEED:  good_need_q  <= cfg_wdata_i[2:0];
        clht_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= in_cmd_i;
      slot_q    <= in_slot_i;
      stv_q     <= in_status_value_i;
      loss_q    <= in_loss_pm_i;
      samples_q <= in_sample_size_i;
      now_q     <= in_now_ms_i;
    end
  end

  assign rd_en = cmd_i.load | cmd_i.scan_rd;
  assign raddr = cmd_i.load ? SW'(in_slot_i) : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (rd_en) begin
        valid_rd_q <= valid_q[raddr];
      end
      if (cmd_i.exec && ex_valid_set) begin
        valid_q[SW'(slot_q)] <= 1'b1;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.scan_chk) begin
        idx_q <= idx_q + SW'(1);
        cnt_q <= cnt_inc;
      end
    end
  end

  assign in_range  = (32'(slot_q) < clht_pkg::SLOT_COUNT);
  assign was_valid = in_range && valid_rd_q;
  assign stv_clamp = (stv_q > 3'(clht_pkg::ST_OFFLINE)) ? clht_pkg::ST_OFFLINE : stv_q;

  always_comb begin
    bad_n  = rd_data_q.bad;
    good_n = rd_data_q.good;
    if (samples_q >= min_sample_q) begin
      if (loss_q >= degrade_q) begin
        bad_n  = clht_pkg::bump(rd_data_q.bad, bad_need_q);
        good_n = '0;
      end else if (loss_q <= recover_q) begin
        good_n = clht_pkg::bump(rd_data_q.good, good_need_q);
        bad_n  = '0;
      end else begin
        bad_n  = '0;
        good_n = '0;
      end
    end
    rep_status = rd_data_q.status;
    if (rd_data_q.status != clht_pkg::ST_LOCKED && rd_data_q.status != clht_pkg::ST_OFFLINE) begin
      if (bad_n >= bad_need_q) begin
        rep_status = clht_pkg::ST_DEGRADED;
      end else if (good_n >= good_need_q) begin
        rep_status = clht_pkg::ST_ONLINE;
      end
    end
  end

  always_comb begin
    rec_new      = rd_data_q;
    ex_we        = 1'b0;
    ex_valid_set = 1'b0;
    upd          = 1'b0;
    ex_found     = 1'b0;
    ex_status    = '0;
    case (cmd_q)
      clht_pkg::CMD_REGISTER: begin
        if (in_range) begin
          ex_we             = 1'b1;
          ex_valid_set      = 1'b1;
          rec_new.status    = stv_clamp;
          rec_new.seen_ms   = now_q;
          rec_new.bad       = '0;
          rec_new.good      = '0;
          ex_found          = was_valid;
          ex_status         = stv_clamp;
        end
      end
      clht_pkg::CMD_SET: begin
        upd            = was_valid;
        rec_new.status = stv_clamp;
      end
      clht_pkg::CMD_TOUCH: begin
        upd             = was_valid;
        rec_new.seen_ms = now_q;
        if (rd_data_q.status == clht_pkg::ST_CONNECTING ||
            rd_data_q.status == clht_pkg::ST_OFFLINE) begin
          rec_new.status = clht_pkg::ST_ONLINE;
        end
      end
      clht_pkg::CMD_REPORT: begin
        upd             = was_valid;
        rec_new.seen_ms = now_q;
        rec_new.bad     = bad_n;
        rec_new.good    = good_n;
        rec_new.status  = rep_status;
      end
      clht_pkg::CMD_REFRESH: begin
        upd             = was_valid;
        rec_new.seen_ms = now_q;
      end
      default: ;
    endcase
    if (upd) begin
      ex_we     = 1'b1;
      ex_found  = 1'b1;
      ex_status = rec_new.status;
    end
  end

  assign hit = valid_rd_q && (rd_data_q.status != clht_pkg::ST_OFFLINE) &&
               ((now_q - rd_data_q.seen_ms) > timeout_q);
  assign cnt_inc   = (hit && cnt_q != clht_pkg::COUNT_MAX) ? cnt_q + 7'd1 : cnt_q;
  assign scan_last = (idx_q == SW'(clht_pkg::SLOT_COUNT - 1));

  always_comb begin
    rec_exp        = rd_data_q;
    rec_exp.status = clht_pkg::ST_OFFLINE;
  end

  always_comb begin
    mem_we    = 1'b0;
    waddr     = SW'(slot_q);
    mem_wdata = rec_new;
    if (cmd_i.exec) begin
      mem_we = ex_we;
    end else if (cmd_i.scan_chk) begin
      mem_we    = hit;
      waddr     = idx_q;
      mem_wdata = rec_exp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_found_q  <= ex_found;
      res_status_q <= ex_status;
      res_count_q  <= '0;
    end else if (cmd_i.scan_chk && scan_last) begin
      res_found_q  <= 1'b1;
      res_status_q <= '0;
      res_count_q  <= cnt_inc;
    end
    if (cmd_i.push) begin
      out_found_q  <= res_found_q;
      out_status_q <= res_status_q;
      out_count_q  <= res_count_q;
    end
  end

  assign sts_o.is_scan   = (cmd_q == clht_pkg::CMD_EXPIRE);
  assign sts_o.scan_last = scan_last;

  assign out_found_o         = out_found_q;
  assign out_status_out_o    = out_status_q;
  assign out_expired_count_o = out_count_q;

endmodule

// ===== hdl/client_link_health_tracker_core.sv =====
// Channel   Role    Width of payload   Contents
// req_i     sink    86 bits            cmd, slot, status_value, loss_pm,
//                                      sample_size, now_ms
// rsp_o     source  11 bits            found, status_out, expired_count
// cfg_*     write   3-bit index        32-bit data, no read-back
//
// A slot command goes from transfer to result by accept, one read-modify-write
// of the slot record memory, and a push into the output register.
// An expire scan walks the record memory, reading and then checking each slot.
// Reset clears the valid bits and control state and loads the configuration defaults;
// records need no clearing. A stalled result waits in the output register while the
// next request is taken in, and the block stalls only when a second result is ready.
module client_link_health_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  clht_in_if.sink     req_i,
  clht_out_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  clht_pkg::dp_cmd_t dp_cmd;
  clht_pkg::dp_sts_t dp_sts;

  clht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  clht_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .sts_o               (dp_sts),
    .in_cmd_i            (req_i.cmd),
    .in_slot_i           (req_i.slot),
    .in_status_value_i   (req_i.status_value),
    .in_loss_pm_i        (req_i.loss_pm),
    .in_sample_size_i    (req_i.sample_size),
    .in_now_ms_i         (req_i.now_ms),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_found_o         (rsp_o.found),
    .out_status_out_o    (rsp_o.status_out),
    .out_expired_count_o (rsp_o.expired_count)
  );

`ifndef SYNTHESIS
  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while another was in flight");

  // A new result must never overwrite one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.push |-> (!rsp_o.valid || rsp_o.ready))
    else $error("output register overwritten before transfer");

  // The scan ends only after the final slot has been checked.
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.scan_chk && dp_sts.scan_last |=> !dp_cmd.scan_rd && !dp_cmd.scan_chk)
    else $error("expire scan continued past the last slot");
`endif

endmodule

// ===== sim/tb_client_link_health_tracker_core.sv =====
module tb_client_link_health_tracker_core;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [2:0] ST_BEYOND    = 3'd7;
  localparam int         IDLE_LIMIT   = 4000;
  localparam int         PHASE_ITEMS  = 200;
  localparam int         PHASES       = 9;
  localparam int         REG_COUNT    = 6;

  typedef struct packed {
    logic       found;
    logic [2:0] status;
    logic [6:0] count;
  } reply_t;

  class health_table_checker;
    logic        valid_q  [clht_pkg::SLOT_COUNT];
    logic [2:0]  status_q [clht_pkg::SLOT_COUNT];
    logic [31:0] seen_q   [clht_pkg::SLOT_COUNT];
    logic [2:0]  bad_q    [clht_pkg::SLOT_COUNT];
    logic [2:0]  good_q   [clht_pkg::SLOT_COUNT];
    logic [31:0] min_samples;
    logic [9:0]  degrade_at;
    logic [9:0]  recover_at;
    logic [2:0]  bad_need;
    logic [2:0]  good_need;
    logic [31:0] silence_limit;
    reply_t      pending_replies[$];
    int          mismatches;

    function new();
      min_samples   = clht_pkg::MIN_SAMPLE_RST;
      degrade_at    = clht_pkg::DEGRADE_RST;
      recover_at    = clht_pkg::RECOVER_RST;
      bad_need      = clht_pkg::BAD_NEED_RST;
      good_need     = clht_pkg::GOOD_NEED_RST;
      silence_limit = clht_pkg::TIMEOUT_RST;
      mismatches    = 0;
      foreach (valid_q[i]) begin
        valid_q[i]  = 1'b0;
        status_q[i] = clht_pkg::ST_CONNECTING;
        seen_q[i]   = '0;
        bad_q[i]    = '0;
        good_q[i]   = '0;
      end
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        clht_pkg::CFG_MIN_SAMPLE: min_samples   = data;
        clht_pkg::CFG_DEGRADE:    degrade_at    = data[9:0];
        clht_pkg::CFG_RECOVER:    recover_at    = data[9:0];
        clht_pkg::CFG_BAD_NEED:   bad_need      = data[2:0];
        clht_pkg::CFG_GOOD_NEED:  good_need     = data[2:0];
        clht_pkg::CFG_TIMEOUT:    silence_limit = data;
        default: ;
      endcase
    endfunction

    // A window counter grows by one and never passes its configured limit.
    function logic [2:0] sat_inc(logic [2:0] c, logic [2:0] lim);
      return ({1'b0, c} + 4'd1 >= {1'b0, lim}) ? lim : c + 3'd1;
    endfunction

    function logic [2:0] clamp_status(logic [2:0] s);
      return (s > clht_pkg::ST_OFFLINE) ? clht_pkg::ST_OFFLINE : s;
    endfunction

    function void take_request(logic [2:0] cmd, logic [5:0] slot, logic [2:0] stv,
                               logic [9:0] loss, logic [31:0] samples, logic [31:0] now);
      reply_t      r;
      logic        was;
      logic [31:0] age;
      int          i;
      r   = '0;
      was = valid_q[slot];
      case (cmd)
        clht_pkg::CMD_EXPIRE: begin
          r.found = 1'b1;
          for (i = 0; i < clht_pkg::SLOT_COUNT; i++) begin
            age = now - seen_q[i];
            if (valid_q[i] && status_q[i] != clht_pkg::ST_OFFLINE && age > silence_limit) begin
              status_q[i] = clht_pkg::ST_OFFLINE;
              if (r.count != clht_pkg::COUNT_MAX) r.count = r.count + 7'd1;
            end
          end
        end
        clht_pkg::CMD_REGISTER: begin
          valid_q[slot]  = 1'b1;
          status_q[slot] = clamp_status(stv);
          seen_q[slot]   = now;
          bad_q[slot]    = '0;
          good_q[slot]   = '0;
          r.found        = was;
          r.status       = status_q[slot];
        end
        clht_pkg::CMD_SET, clht_pkg::CMD_TOUCH, clht_pkg::CMD_REPORT,
        clht_pkg::CMD_REFRESH: begin
          if (was) begin
            if (cmd == clht_pkg::CMD_SET) begin
              status_q[slot] = clamp_status(stv);
            end else begin
              seen_q[slot] = now;
            end
            if (cmd == clht_pkg::CMD_TOUCH &&
                (status_q[slot] == clht_pkg::ST_CONNECTING ||
                 status_q[slot] == clht_pkg::ST_OFFLINE)) begin
              status_q[slot] = clht_pkg::ST_ONLINE;
            end
            if (cmd == clht_pkg::CMD_REPORT) begin
              if (samples >= min_samples) begin
                if (loss >= degrade_at) begin
                  bad_q[slot]  = sat_inc(bad_q[slot], bad_need);
                  good_q[slot] = '0;
                end else if (loss <= recover_at) begin
                  good_q[slot] = sat_inc(good_q[slot], good_need);
                  bad_q[slot]  = '0;
                end else begin
                  bad_q[slot]  = '0;
                  good_q[slot] = '0;
                end
              end
              if (status_q[slot] != clht_pkg::ST_LOCKED &&
                  status_q[slot] != clht_pkg::ST_OFFLINE) begin
                if (bad_q[slot] >= bad_need) begin
                  status_q[slot] = clht_pkg::ST_DEGRADED;
                end else if (good_q[slot] >= good_need) begin
                  status_q[slot] = clht_pkg::ST_ONLINE;
                end
              end
            end
            r.found  = 1'b1;
            r.status = status_q[slot];
          end
        end
        default: ;
      endcase
      pending_replies.push_front(r);
    endfunction

    function void check_response(logic found, logic [2:0] status, logic [6:0] count);
      reply_t e;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transfer: found=%0d status=%0d count=%0d",
                   found, status, count);
        end
      end else begin
        e = pending_replies.pop_back();
        if (found !== e.found || status !== e.status || count !== e.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected found=%0d status=%0d count=%0d, %s",
                     e.found, e.status, e.count, "got:");
            $display("  found=%0d status=%0d count=%0d", found, status, count);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  clht_in_if  req_if ();
  clht_out_if rsp_if ();

  health_table_checker table_chk;
  bit          tx_quiet;
  bit          rx_quiet;
  int          idle_cycles;
  logic [31:0] clock_ms;
  logic [5:0]  pool_base;
  logic [31:0] next_cfg [REG_COUNT];

  client_link_health_tracker_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
      table_chk.take_request(req_if.cmd, req_if.slot, req_if.status_value,
                             req_if.loss_pm, req_if.sample_size, req_if.now_ms);
    end
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      table_chk.check_response(rsp_if.found, rsp_if.status_out, rsp_if.expired_count);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int hold;
    int taken;
    taken = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      hold = rx_quiet ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      taken++;
    end
  end

  task automatic send_request(input logic [2:0] cmd, input logic [5:0] slot,
                              input logic [2:0] stv, input logic [9:0] loss,
                              input logic [31:0] samples, input logic [31:0] now);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.slot         <= slot;
    req_if.status_value <= stv;
    req_if.loss_pm      <= loss;
    req_if.sample_size  <= samples;
    req_if.now_ms       <= now;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic drain_replies();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (table_chk.pending_replies.size() != 0);
  endtask

  task automatic load_settings();
    int i;
    drain_replies();
    repeat (4) @(posedge clk_i);
    for (i = 0; i < REG_COUNT; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= next_cfg[i];
      table_chk.set_register(3'(i), next_cfg[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int pause_at);
    int          k;
    int          pick;
    logic [2:0]  cmd;
    logic [5:0]  slot;
    logic [2:0]  stv;
    logic [9:0]  loss;
    logic [31:0] samples;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 10)      cmd = clht_pkg::CMD_REGISTER;
      else if (pick < 18) cmd = clht_pkg::CMD_SET;
      else if (pick < 30) cmd = clht_pkg::CMD_TOUCH;
      else if (pick < 74) cmd = clht_pkg::CMD_REPORT;
      else if (pick < 85) cmd = clht_pkg::CMD_REFRESH;
      else if (pick < 96) cmd = clht_pkg::CMD_EXPIRE;
      else                cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      slot = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'(pool_base + $urandom_range(0, 7));
      stv = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 3))
        0:       loss = 10'($urandom_range(table_chk.degrade_at, 1000));
        1:       loss = 10'($urandom_range(0, table_chk.recover_at));
        2:       loss = 10'($urandom_range(table_chk.recover_at, table_chk.degrade_at));
        default: loss = 10'($urandom_range(0, 1000));
      endcase
      case ($urandom_range(0, 7))
        0:       samples = $urandom;
        1:       samples = table_chk.min_samples - 32'd1 - $urandom_range(0, 20);
        2:       samples = table_chk.min_samples;
        default: samples = table_chk.min_samples + $urandom_range(0, 50);
      endcase
      clock_ms = clock_ms + $urandom_range(0, 1500);
      if ($urandom_range(0, 39) == 0) clock_ms = clock_ms + $urandom;
      send_request(cmd, slot, stv, loss, samples, clock_ms);
      if (k == pause_at) drain_replies();
    end
  endtask

  initial begin
    int p;
    int n;
    table_chk           = new();
    tx_quiet            = 1'b0;
    rx_quiet            = 1'b0;
    idle_cycles         = 0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = clht_pkg::CFG_MIN_SAMPLE;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.cmd          = clht_pkg::CMD_REGISTER;
    req_if.slot         = '0;
    req_if.status_value = clht_pkg::ST_CONNECTING;
    req_if.loss_pm      = '0;
    req_if.sample_size  = '0;
    req_if.now_ms       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(clht_pkg::CMD_EXPIRE, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd0);
    send_request(clht_pkg::CMD_SET, 6'd0, clht_pkg::ST_ONLINE, 10'd0, 32'd0, 32'd0);
    send_request(clht_pkg::CMD_TOUCH, 6'd63, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd0);
    send_request(clht_pkg::CMD_REPORT, 6'd1, clht_pkg::ST_CONNECTING, 10'd1000,
                 32'hFFFF_FFFF, 32'd0);
    send_request(clht_pkg::CMD_REFRESH, 6'd2, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd0);
    send_request(CMD_SPARE_LO, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd0);
    send_request(CMD_SPARE_HI, 6'd63, ST_BEYOND, 10'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(clht_pkg::CMD_REGISTER, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0,
                 32'd100);
    send_request(clht_pkg::CMD_REGISTER, 6'd63, ST_BEYOND, 10'd0, 32'd0, 32'd0);
    send_request(clht_pkg::CMD_REGISTER, 6'd62, clht_pkg::ST_ONLINE, 10'd0, 32'd0,
                 32'hFFFF_FFF0);
    send_request(clht_pkg::CMD_REGISTER, 6'd5, clht_pkg::ST_LOCKED, 10'd0, 32'd0, 32'd200);
    send_request(clht_pkg::CMD_REGISTER, 6'd1, clht_pkg::ST_ONLINE, 10'd0, 32'd0, 32'd300);
    send_request(clht_pkg::CMD_REGISTER, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0,
                 32'd400);
    send_request(clht_pkg::CMD_TOUCH, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd500);
    send_request(clht_pkg::CMD_SET, 6'd0, ST_BEYOND, 10'd0, 32'd0, 32'd0);
    send_request(clht_pkg::CMD_TOUCH, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0, 32'd500);
    send_request(clht_pkg::CMD_REPORT, 6'd1, clht_pkg::ST_CONNECTING, 10'd1000, 32'd199,
                 32'd300);
    for (n = 0; n < 3; n++) begin
      send_request(clht_pkg::CMD_REPORT, 6'd1, clht_pkg::ST_CONNECTING, 10'd1000, 32'd200,
                   32'd300);
    end
    send_request(clht_pkg::CMD_REPORT, 6'd1, clht_pkg::ST_CONNECTING, 10'd30,
                 32'hFFFF_FFFF, 32'd300);
    for (n = 0; n < 5; n++) begin
      send_request(clht_pkg::CMD_REPORT, 6'd1, clht_pkg::ST_CONNECTING, 10'd0, 32'd200,
                   32'd300);
    end
    send_request(clht_pkg::CMD_REPORT, 6'd5, clht_pkg::ST_CONNECTING, 10'd1000, 32'd200,
                 32'd200);
    send_request(clht_pkg::CMD_REFRESH, 6'd63, clht_pkg::ST_CONNECTING, 10'd0, 32'd0,
                 32'hFFFF_FFFF);
    // The slot seen just before the time counter wrapped is still fresh here.
    send_request(clht_pkg::CMD_EXPIRE, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0,
                 32'h0000_0010);
    send_request(clht_pkg::CMD_EXPIRE, 6'd0, clht_pkg::ST_CONNECTING, 10'd0, 32'd0,
                 32'h0000_0010 + 32'd5000);
    drain_replies();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: begin
          next_cfg[clht_pkg::CFG_MIN_SAMPLE] = 32'd0;
          next_cfg[clht_pkg::CFG_DEGRADE]    = 32'd0;
          next_cfg[clht_pkg::CFG_RECOVER]    = 32'd0;
          next_cfg[clht_pkg::CFG_BAD_NEED]   = 32'd1;
          next_cfg[clht_pkg::CFG_GOOD_NEED]  = 32'd1;
          next_cfg[clht_pkg::CFG_TIMEOUT]    = 32'd0;
        end
        2: begin
          next_cfg[clht_pkg::CFG_MIN_SAMPLE] = 32'hFFFF_FFFF;
          next_cfg[clht_pkg::CFG_DEGRADE]    = 32'd1000;
          next_cfg[clht_pkg::CFG_RECOVER]    = 32'd1000;
          next_cfg[clht_pkg::CFG_BAD_NEED]   = 32'd7;
          next_cfg[clht_pkg::CFG_GOOD_NEED]  = 32'd7;
          next_cfg[clht_pkg::CFG_TIMEOUT]    = 32'hFFFF_FFFF;
        end
        3: begin
          // Window limits of zero are reached without any counting.
          next_cfg[clht_pkg::CFG_MIN_SAMPLE] = 32'd100;
          next_cfg[clht_pkg::CFG_DEGRADE]    = 32'd600;
          next_cfg[clht_pkg::CFG_RECOVER]    = 32'd300;
          next_cfg[clht_pkg::CFG_BAD_NEED]   = 32'd0;
          next_cfg[clht_pkg::CFG_GOOD_NEED]  = 32'd0;
          next_cfg[clht_pkg::CFG_TIMEOUT]    = 32'd8000;
        end
        default: begin
          next_cfg[clht_pkg::CFG_MIN_SAMPLE] = $urandom_range(0, 400);
          next_cfg[clht_pkg::CFG_DEGRADE]    = $urandom_range(0, 1000);
          next_cfg[clht_pkg::CFG_RECOVER]    = $urandom_range(0, 1000);
          next_cfg[clht_pkg::CFG_BAD_NEED]   = $urandom_range(1, 7);
          next_cfg[clht_pkg::CFG_GOOD_NEED]  = $urandom_range(1, 7);
          next_cfg[clht_pkg::CFG_TIMEOUT]    = $urandom_range(0, 20000);
        end
      endcase
      if (p != 0) load_settings();
      pool_base = 6'($urandom_range(0, 63));
      clock_ms  = $urandom;
      run_phase(PHASE_ITEMS, (p == 4) ? PHASE_ITEMS / 2 : -1);
    end

    drain_replies();
    repeat (20) @(posedge clk_i);
    if (table_chk.mismatches == 0 && table_chk.pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== client_link_health_tracker_core.f =====
hdl/clht_pkg.sv
hdl/clht_in_if.sv
hdl/clht_out_if.sv
hdl/clht_ctrl.sv
hdl/clht_datapath.sv
hdl/client_link_health_tracker_core.sv
sim/tb_client_link_health_tracker_core.sv
